>>> src/assert_macros.svh
// Assertion helpers; clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GLRP_CHECK(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("glrp check failed");
`define GLRP_CHECK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glrp check failed");
`else
`define GLRP_CHECK(lbl, cond)
`define GLRP_CHECK_IMP(lbl, ante, cons)
`endif

`endif

>>> src/glrp_pkg.sv
package glrp_pkg;

    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    localparam int CNT_W     = 6;
    localparam int H_W       = 16;
    localparam int OUT_W     = 11;
    localparam int DIM_W     = 9;
    localparam int TOTAL_W   = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
    localparam logic [CNT_W-1:0]     RESET_COUNT   = 6'd32;

    typedef struct packed {
        logic [DIM_W-1:0]   rows;
        logic [DIM_W-1:0]   cols;
        logic [TOTAL_W-1:0] total;
    } dims_t;

    // zero counts as one, anything above the maximum saturates
    function automatic logic [DIM_W-1:0] eff_count(input logic [CNT_W-1:0] cnt, input int max_cnt);
        logic [DIM_W-1:0] v;
        v = DIM_W'(cnt);
        if (cnt == '0)
            v = DIM_W'(1);
        else if (int'(cnt) > max_cnt)
            v = DIM_W'(max_cnt);
        return v;
    endfunction

endpackage

>>> src/glrp_engine.sv
`include "assert_macros.svh"

module glrp_engine #(
    parameter int MAX_ROWS = glrp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = glrp_pkg::DEF_MAX_COLS,
    localparam int CAP = MAX_ROWS * MAX_COLS,
    localparam int PW  = $clog2(CAP + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  glrp_pkg::dims_t                 dims,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [glrp_pkg::H_W-1:0] in_height,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [PW-1:0]                   res_len
);

    localparam int AW = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LW = PW;
    localparam int TW = glrp_pkg::TOTAL_W;
    localparam int DW = glrp_pkg::DIM_W;

    localparam logic [2:0] DIR_LEFT  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_UP    = 3'd2;
    localparam logic [2:0] DIR_DOWN  = 3'd3;
    localparam logic [2:0] DIR_END   = 3'd4;

    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_SCANW = 9'b000001000,
        S_NBR   = 9'b000010000,
        S_NBRW  = 9'b000100000,
        S_POP   = 9'b001000000,
        S_POPW  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [AW-1:0]                   addr;
        logic [RW-1:0]                   row;
        logic [CW-1:0]                   col;
        logic [2:0]                      dir;
        logic [LW-1:0]                   m;
        logic signed [glrp_pkg::H_W-1:0] h;
    } frame_t;

    // memories
    logic signed [glrp_pkg::H_W-1:0] h_mem [CAP];
    logic [LW-1:0]                   len_mem [CAP];
    frame_t                          stk_mem [CAP];

    logic                            h_we;
    logic [AW-1:0]                   h_waddr, h_raddr;
    logic signed [glrp_pkg::H_W-1:0] h_rdata;
    logic                            len_we;
    logic [AW-1:0]                   len_waddr, len_raddr;
    logic [LW-1:0]                   len_wdata, len_rdata;
    logic                            stk_we;
    logic [AW-1:0]                   stk_waddr, stk_raddr;
    frame_t                          stk_wdata, stk_rdata;

    always_ff @(posedge clk)
    begin
        if (h_we)
            h_mem[h_waddr] <= in_height;
        h_rdata <= h_mem[h_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[len_waddr] <= len_wdata;
        len_rdata <= len_mem[len_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        stk_rdata <= stk_mem[stk_raddr];
    end

    state_t        state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] clr_reg, clr_next;
    logic [PW-1:0] s_reg, s_next;
    logic [RW-1:0] s_row_reg, s_row_next;
    logic [CW-1:0] s_col_reg, s_col_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic [LW-1:0] best_reg, best_next;
    logic [LW-1:0] child_reg, child_next;
    frame_t        top_reg, top_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            pos_reg   <= '0;
            clr_reg   <= '0;
            s_reg     <= '0;
            s_row_reg <= '0;
            s_col_reg <= '0;
            sp_reg    <= '0;
            best_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            clr_reg   <= clr_next;
            s_reg     <= s_next;
            s_row_reg <= s_row_next;
            s_col_reg <= s_col_next;
            sp_reg    <= sp_next;
            best_reg  <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg   <= top_next;
        child_reg <= child_next;
    end

    // neighbor of the top frame in its current direction
    logic          nb_ok;
    logic [AW-1:0] nb_cell;
    logic [RW-1:0] nb_row;
    logic [CW-1:0] nb_col;
    logic [AW-1:0] cols_a;

    assign cols_a = AW'(dims.cols);

    always_comb
    begin
        nb_ok   = 1'b0;
        nb_cell = top_reg.addr;
        nb_row  = top_reg.row;
        nb_col  = top_reg.col;
        case (top_reg.dir)
            DIR_LEFT:
            begin
                nb_ok   = (top_reg.col != '0);
                nb_cell = top_reg.addr - AW'(1);
                nb_col  = top_reg.col - CW'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok   = (DW'(top_reg.col) + DW'(1) < dims.cols);
                nb_cell = top_reg.addr + AW'(1);
                nb_col  = top_reg.col + CW'(1);
            end
            DIR_UP:
            begin
                nb_ok   = (top_reg.row != '0);
                nb_cell = top_reg.addr - cols_a;
                nb_row  = top_reg.row - RW'(1);
            end
            DIR_DOWN:
            begin
                nb_ok   = (DW'(top_reg.row) + DW'(1) < dims.rows);
                nb_cell = top_reg.addr + cols_a;
                nb_row  = top_reg.row + RW'(1);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    logic [PW-1:0] s_inc;
    logic          s_last;
    logic [LW-1:0] m_inc;
    logic [PW-1:0] sp_dec, sp_dec2;

    assign s_inc   = s_reg + PW'(1);
    assign s_last  = (TW'(s_inc) >= dims.total);
    assign m_inc   = top_reg.m + LW'(1);
    assign sp_dec  = sp_reg - PW'(1);
    assign sp_dec2 = sp_reg - PW'(2);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        clr_next   = clr_reg;
        s_next     = s_reg;
        s_row_next = s_row_reg;
        s_col_next = s_col_reg;
        sp_next    = sp_reg;
        best_next  = best_reg;
        child_next = child_reg;
        top_next   = top_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;

        h_we      = 1'b0;
        h_waddr   = pos_reg[AW-1:0];
        h_raddr   = nb_cell;
        len_we    = 1'b0;
        len_waddr = top_reg.addr;
        len_wdata = m_inc;
        len_raddr = nb_cell;
        stk_we    = 1'b0;
        stk_waddr = sp_dec[AW-1:0];
        stk_wdata = top_reg;
        stk_raddr = sp_dec2[AW-1:0];

        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    h_we = (pos_reg < PW'(CAP));
                    if (TW'(pos_reg) + TW'(1) >= dims.total)
                    begin
                        pos_next   = '0;
                        clr_next   = '0;
                        state_next = S_CLEAR;
                    end
                    else
                        pos_next = pos_reg + PW'(1);
                end
            end
            S_CLEAR:
            begin
                len_we    = 1'b1;
                len_waddr = clr_reg[AW-1:0];
                len_wdata = '0;
                clr_next  = clr_reg + PW'(1);
                if (TW'(clr_reg) + TW'(1) >= dims.total)
                begin
                    s_next     = '0;
                    s_row_next = '0;
                    s_col_next = '0;
                    best_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                h_raddr    = s_reg[AW-1:0];
                len_raddr  = s_reg[AW-1:0];
                state_next = S_SCANW;
            end
            S_SCANW:
            begin
                if (len_rdata == '0)
                begin
                    top_next.addr = s_reg[AW-1:0];
                    top_next.row  = s_row_reg;
                    top_next.col  = s_col_reg;
                    top_next.dir  = DIR_LEFT;
                    top_next.m    = '0;
                    top_next.h    = h_rdata;
                    sp_next       = PW'(1);
                    state_next    = S_NBR;
                end
                else
                begin
                    if (len_rdata > best_reg)
                        best_next = len_rdata;
                    state_next = s_last ? S_DONE : S_SCAN;
                end
            end
            S_NBR:
            begin
                if (top_reg.dir == DIR_END)
                    state_next = S_POP;
                else if (nb_ok)
                    state_next = S_NBRW;
                else
                    top_next.dir = top_reg.dir + 3'd1;
            end
            S_NBRW:
            begin
                state_next   = S_NBR;
                top_next.dir = top_reg.dir + 3'd1;
                if (h_rdata > top_reg.h)
                begin
                    if (len_rdata != '0)
                    begin
                        if (len_rdata > top_reg.m)
                            top_next.m = len_rdata;
                    end
                    else
                    begin
                        // descend: park this frame, neighbor becomes the top
                        stk_we        = 1'b1;
                        stk_waddr     = sp_dec[AW-1:0];
                        stk_wdata     = top_reg;
                        stk_wdata.dir = top_reg.dir + 3'd1;
                        top_next.addr = nb_cell;
                        top_next.row  = nb_row;
                        top_next.col  = nb_col;
                        top_next.dir  = DIR_LEFT;
                        top_next.m    = '0;
                        top_next.h    = h_rdata;
                        sp_next       = sp_reg + PW'(1);
                    end
                end
            end
            S_POP:
            begin
                len_we     = 1'b1;
                child_next = m_inc;
                sp_next    = sp_dec;
                if (sp_reg == PW'(1))
                begin
                    if (m_inc > best_reg)
                        best_next = m_inc;
                    state_next = s_last ? S_DONE : S_SCAN;
                end
                else
                    state_next = S_POPW;
            end
            S_POPW:
            begin
                top_next = stk_rdata;
                if (child_reg > stk_rdata.m)
                    top_next.m = child_reg;
                state_next = S_NBR;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // next start cell in row-major order
        if ((state_reg == S_SCANW && len_rdata != '0) ||
            (state_reg == S_POP && sp_reg == PW'(1)))
        begin
            s_next = s_inc;
            if (DW'(s_col_reg) + DW'(1) >= dims.cols)
            begin
                s_col_next = '0;
                s_row_next = s_row_reg + RW'(1);
            end
            else
                s_col_next = s_col_reg + CW'(1);
        end
    end

    assign res_len = best_reg;

    `GLRP_CHECK(a_sp_bound, TW'(sp_reg) <= dims.total)
    `GLRP_CHECK_IMP(a_pop_nonempty, state_reg == S_POP, sp_reg != '0)
    `GLRP_CHECK_IMP(a_len_written_nonzero, len_we && state_reg != S_CLEAR, len_wdata != '0)
    `GLRP_CHECK_IMP(a_load_stack_empty, in_ready, sp_reg == '0 || state_reg == S_LOAD)

endmodule

>>> src/grid_longest_rising_path_top.sv
// Longest strictly rising 4-neighbor path over a loaded height grid.
// s_axis: one transaction per cell, row-major, 16-bit signed height; taken
//   one per cycle while the block is loading.
// cfg: register 0 = row_count, register 1 = col_count (6 bits each); zero
//   counts as one, values above the maximum saturate. Write while idle.
// m_axis: after the last cell of a frame, one transaction with the longest
//   path length (cell count), loading again once the result is registered.
// Flow: after the last cell, a clear pass over the rows*cols length entries,
//   then a depth-first search: a scan and a wait state per start cell, a
//   check state plus a wait state per neighbor in bounds, and a pop state
//   (plus a pop-wait unless a start cell) per finished cell. The search is
//   bound by the single read port of the length and height memories.
// Reset: counts return to 32, the load position to the first cell.
// Stall: the result sits in an output register; if it is still unaccepted
//   when the next result is ready, the block waits before loading again.
module grid_longest_rising_path_top #(
    parameter int MAX_ROWS = glrp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = glrp_pkg::DEF_MAX_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,   // [15:0] cell_height
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,   // [10:0] longest_path
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [glrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [glrp_pkg::CNT_W-1:0]          cfg_data
);

    localparam int CAP = MAX_ROWS * MAX_COLS;
    localparam int PW  = $clog2(CAP + 1);

    logic [glrp_pkg::CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [glrp_pkg::CNT_W-1:0] col_cnt_reg, col_cnt_next;
    glrp_pkg::dims_t            dims;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                glrp_pkg::REG_ROW_COUNT: row_cnt_next = cfg_data;
                glrp_pkg::REG_COL_COUNT: col_cnt_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= glrp_pkg::RESET_COUNT;
            col_cnt_reg <= glrp_pkg::RESET_COUNT;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    always_comb
    begin
        dims.rows  = glrp_pkg::eff_count(row_cnt_reg, MAX_ROWS);
        dims.cols  = glrp_pkg::eff_count(col_cnt_reg, MAX_COLS);
        dims.total = glrp_pkg::TOTAL_W'(dims.rows * dims.cols);
    end

    logic          res_valid, res_ready;
    logic [PW-1:0] res_len;

    glrp_engine #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims      (dims),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_height (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_len   (res_len)
    );

    logic                       out_valid_reg, out_valid_next;
    logic [glrp_pkg::OUT_W-1:0] out_len_reg, out_len_next;

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_len_next   = out_len_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_len_next   = glrp_pkg::OUT_W'(res_len);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_len_reg <= out_len_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_len_reg};

endmodule

>>> bench/grid_longest_rising_path_top_tb.sv
`timescale 1ns / 100ps

module grid_longest_rising_path_top_tb;

    localparam int CNT_W     = glrp_pkg::CNT_W;
    localparam int H_W       = glrp_pkg::H_W;
    localparam int OUT_W     = glrp_pkg::OUT_W;
    localparam int CFG_IDX_W = glrp_pkg::CFG_IDX_W;
    localparam int MAX_R     = glrp_pkg::DEF_MAX_ROWS;
    localparam int MAX_C     = glrp_pkg::DEF_MAX_COLS;
    localparam int CAP       = MAX_R * MAX_C;
    localparam int CYC_LIMIT = 3000000;

    typedef enum int {PAT_FLAT, PAT_RAMP, PAT_RAND, PAT_NARROW} fill_t;

    typedef struct {
        logic [CNT_W-1:0] rows_raw;
        logic [CNT_W-1:0] cols_raw;
        fill_t            fill;
        logic [H_W-1:0]   level;      // flat height / ramp start
        int               typed_len;  // 0: take the predictor's answer
    } frame_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0] cfg_data;

    grid_longest_rising_path_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // grid shadow
    logic signed [H_W-1:0] grid_h [CAP];
    int unsigned           path_len [CAP];
    int unsigned           grid_rows, grid_cols, cells_in;
    int                    frame_typed;
    logic [OUT_W-1:0]      pending_len [$];
    int                    fail_cnt, cells_sent, cyc;
    bit                    calm;

    function automatic int unsigned sat_count(logic [CNT_W-1:0] raw, int max_cnt);
        if (raw == '0)
            return 1;
        if (int'(raw) > max_cnt)
            return unsigned'(max_cnt);
        return 32'(raw);
    endfunction

    // memoized climb: length of the longest strictly rising path from cell v
    function automatic int unsigned climb(int unsigned v);
        int unsigned r, c, best, nb, d;
        bit ok;
        if (path_len[v] != 0)
            return path_len[v];
        r = v / grid_cols;
        c = v % grid_cols;
        best = 0;
        nb = 0;
        for (d = 0; d < 4; d++)
        begin
            ok = 1'b0;
            case (d)
                0:
                begin
                    ok = (c > 0);
                    nb = v - 1;
                end
                1:
                begin
                    ok = (c + 1 < grid_cols);
                    nb = v + 1;
                end
                2:
                begin
                    ok = (r > 0);
                    nb = v - grid_cols;
                end
                default:
                begin
                    ok = (r + 1 < grid_rows);
                    nb = v + grid_cols;
                end
            endcase
            if (ok && grid_h[nb] > grid_h[v])
            begin
                if (climb(nb) > best)
                    best = climb(nb);
            end
        end
        path_len[v] = best + 1;
        return best + 1;
    endfunction

    function automatic logic [OUT_W-1:0] longest_rise();
        int unsigned v, best;
        best = 0;
        for (v = 0; v < CAP; v++)
            path_len[v] = 0;
        for (v = 0; v < grid_rows * grid_cols; v++)
            if (climb(v) > best)
                best = climb(v);
        return OUT_W'(best);
    endfunction

    function automatic void queue_expected(logic [OUT_W-1:0] len);
        pending_len.insert(pending_len.size(), len);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_len.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %0d",
                         $time, m_axis_tdata[OUT_W-1:0]);
                fail_cnt++;
            end
            else
            begin
                if (m_axis_tdata[OUT_W-1:0] !== pending_len[0])
                begin
                    $display("%0t longest_path mismatch: expected %0d, actual %0d",
                             $time, pending_len[0], m_axis_tdata[OUT_W-1:0]);
                    fail_cnt++;
                end
                void'(pending_len.pop_front());
            end
        end
    end

    // result ready with random stalls
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 6);
            if (n > 0)
            begin
                @(negedge clk) m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk) m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // settle, then set the grid size
    task automatic set_dims(logic [CNT_W-1:0] r, logic [CNT_W-1:0] c);
        wait (pending_len.size() == 0);
        repeat (20) @(posedge clk);
        write_reg(glrp_pkg::REG_ROW_COUNT, r);
        write_reg(glrp_pkg::REG_COL_COUNT, c);
        grid_rows = sat_count(r, MAX_R);
        grid_cols = sat_count(c, MAX_C);
    endtask

    task automatic send_cell(logic [H_W-1:0] h);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            @(negedge clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        do @(posedge clk); while (!s_axis_tready);
        grid_h[cells_in] = h;
        cells_in++;
        cells_sent++;
        if (cells_in >= grid_rows * grid_cols)
        begin
            cells_in = 0;
            queue_expected(frame_typed != 0 ? OUT_W'(frame_typed) : longest_rise());
        end
    endtask

    task automatic send_frame(fill_t fill, logic [H_W-1:0] level);
        int unsigned i;
        logic [H_W-1:0] h;
        calm = ($urandom_range(0, 3) == 0);
        for (i = 0; i < grid_rows * grid_cols; i++)
        begin
            case (fill)
                PAT_FLAT:   h = level;
                PAT_RAMP:   h = level + H_W'(i);
                PAT_RAND:   h = H_W'($urandom);
                default:    h = H_W'($urandom_range(0, 6) - 3);
            endcase
            send_cell(h);
        end
        @(negedge clk) s_axis_tvalid <= 1'b0;
    endtask

    frame_row_t plan [8] = '{
        '{6'd0,  6'd0,  PAT_FLAT,   16'h8000, 1},   // zero counts as one
        '{6'd1,  6'd1,  PAT_FLAT,   16'h7FFF, 1},
        '{6'd63, 6'd1,  PAT_RAMP,   16'h8000, 32},  // saturated rows, all rising
        '{6'd1,  6'd63, PAT_RAMP,   16'h7FE0, 32},
        '{6'd2,  6'd3,  PAT_FLAT,   16'h0000, 1},   // equal heights never step
        '{6'd3,  6'd3,  PAT_RAND,   16'h0000, 0},
        '{6'd4,  6'd2,  PAT_NARROW, 16'h0000, 0},
        '{6'd20, 6'd20, PAT_NARROW, 16'h0000, 0}
    };

    initial
    begin
        logic [CNT_W-1:0] r, c;
        fill_t f;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid = 1'b0;
        cfg_index = glrp_pkg::REG_ROW_COUNT;
        cfg_data  = '0;
        cells_sent = 0;
        cells_in = 0;
        calm = 1'b0;
        grid_rows = MAX_R;
        grid_cols = MAX_C;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        foreach (plan[k])
        begin
            set_dims(plan[k].rows_raw, plan[k].cols_raw);
            frame_typed = plan[k].typed_len;
            send_frame(plan[k].fill, plan[k].level);
        end
        frame_typed = 0;

        while (cells_sent < 850)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                r = ($urandom_range(0, 1) != 0) ? 6'd0 : CNT_W'($urandom_range(33, 63));
                c = CNT_W'($urandom_range(1, 3));
            end
            else
            begin
                r = CNT_W'($urandom_range(1, 6));
                c = CNT_W'($urandom_range(1, 6));
            end
            case ($urandom_range(0, 9))
                0:       f = PAT_FLAT;
                1:       f = PAT_RAMP;
                2, 3:    f = PAT_RAND;
                default: f = PAT_NARROW;
            endcase
            set_dims(r, c);
            send_frame(f, H_W'($urandom));
        end

        wait (pending_len.size() == 0);
        repeat (100) @(posedge clk);
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/glrp_pkg.sv
src/glrp_engine.sv
src/grid_longest_rising_path_top.sv
bench/grid_longest_rising_path_top_tb.sv
